[rtl/tsa_pkg.sv]
package tsa_pkg;

  localparam int COORD_W    = 16;
  localparam int SIDE_W     = 17;
  localparam int ANG_W      = 16;
  localparam int RAD_W      = 2 * SIDE_W;
  localparam int REM_W      = SIDE_W + 2;
  localparam int NUM_W      = 36;
  localparam int DEN_W      = 35;
  localparam int FRAC_W     = 16;
  localparam int DIVR_W     = DEN_W + FRAC_W + 1;
  localparam int Q_W        = FRAC_W + 1;
  localparam int SQRT_STEPS = SIDE_W;
  localparam int CX_W       = 20;
  localparam int CZ_W       = 26;
  localparam int ATAN_W     = 22;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX        = 24;

  localparam logic [CZ_W-1:0]  DEG90_Q16 = CZ_W'(5898240);
  localparam logic [ANG_W-1:0] DEG180_Q8 = ANG_W'(46080);
  localparam logic [RAD_W-1:0] ONE_SQ    = RAD_W'(64'h1_0000_0000);

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [SIDE_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_st_t;

  typedef struct packed {
    logic [DIVR_W-1:0] rem;
    logic [DEN_W-1:0]  den;
    logic [Q_W-1:0]    q;
  } div_st_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_st_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic [ATAN_W-1:0] atan_q16(input int i);
    logic [ATAN_W-1:0] r;
    case (i)
      0:  r = ATAN_W'(2949120);
      1:  r = ATAN_W'(1740967);
      2:  r = ATAN_W'(919879);
      3:  r = ATAN_W'(466945);
      4:  r = ATAN_W'(234379);
      5:  r = ATAN_W'(117304);
      6:  r = ATAN_W'(58666);
      7:  r = ATAN_W'(29335);
      8:  r = ATAN_W'(14668);
      9:  r = ATAN_W'(7334);
      10: r = ATAN_W'(3667);
      11: r = ATAN_W'(1833);
      12: r = ATAN_W'(917);
      13: r = ATAN_W'(458);
      14: r = ATAN_W'(229);
      15: r = ATAN_W'(115);
      16: r = ATAN_W'(57);
      17: r = ATAN_W'(29);
      18: r = ATAN_W'(14);
      19: r = ATAN_W'(7);
      20: r = ATAN_W'(4);
      21: r = ATAN_W'(2);
      22: r = ATAN_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/tsa_item_if.sv]
interface tsa_item_if import tsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [COORD_W-1:0] vert_a_x;
  logic signed [COORD_W-1:0] vert_a_y;
  logic signed [COORD_W-1:0] vert_b_x;
  logic signed [COORD_W-1:0] vert_b_y;
  logic signed [COORD_W-1:0] vert_c_x;
  logic signed [COORD_W-1:0] vert_c_y;
  logic [SIDE_W-1:0]         len_a_in;
  logic [SIDE_W-1:0]         len_b_in;
  logic [SIDE_W-1:0]         len_c_in;

  modport source (
    output valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
           len_a_in, len_b_in, len_c_in,
    input  ready
  );
  modport sink (
    input  valid, op, vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
           len_a_in, len_b_in, len_c_in,
    output ready
  );
endinterface

[rtl/tsa_result_if.sv]
interface tsa_result_if import tsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] len_a_out;
  logic [SIDE_W-1:0] len_b_out;
  logic [SIDE_W-1:0] len_c_out;
  logic [ANG_W-1:0]  angle_at_a;
  logic [ANG_W-1:0]  angle_at_b;
  logic [ANG_W-1:0]  angle_at_c;
  logic              bad_triangle;

  modport source (
    output valid, len_a_out, len_b_out, len_c_out, angle_at_a, angle_at_b, angle_at_c,
           bad_triangle,
    input  ready
  );
  modport sink (
    input  valid, len_a_out, len_b_out, len_c_out, angle_at_a, angle_at_b, angle_at_c,
           bad_triangle,
    output ready
  );
endinterface

[rtl/tsa_sqrt_cell.sv]
module tsa_sqrt_cell import tsa_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  sqrt_st_t cur,
  output sqrt_st_t nxt
);

  logic [REM_W+1:0] rem_w;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  // bring down two radicand bits, try root digit one
  assign rem_w = {cur.rem, cur.rad[RAD_W-1 -: 2]};
  assign trial = {2'b00, cur.root, 2'b01};
  assign diff  = rem_w - trial;
  assign fits  = rem_w >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      nxt.rem  <= fits ? diff[REM_W-1:0] : rem_w[REM_W-1:0];
      nxt.root <= {cur.root[SIDE_W-2:0], fits};
      nxt.rad  <= {cur.rad[RAD_W-3:0], 2'b00};
    end
  end

endmodule

[rtl/tsa_div_cell.sv]
module tsa_div_cell import tsa_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic    clk,
  input  logic    en,
  input  div_st_t cur,
  output div_st_t nxt
);

  logic [DIVR_W-1:0] dsh;
  logic              fits;

  assign dsh  = DIVR_W'(cur.den) << SHIFT;
  assign fits = cur.rem >= dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      nxt.rem <= fits ? cur.rem - dsh : cur.rem;
      nxt.den <= cur.den;
      nxt.q   <= {cur.q[Q_W-2:0], fits};
    end
  end

endmodule

[rtl/tsa_cordic_cell.sv]
module tsa_cordic_cell import tsa_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       en,
  input  cordic_st_t cur,
  output cordic_st_t nxt
);

  logic signed [CX_W-1:0] xs;
  logic signed [CX_W-1:0] ys;
  logic signed [CZ_W-1:0] step;

  assign xs   = cur.x >>> IDX;
  assign ys   = cur.y >>> IDX;
  assign step = CZ_W'(atan_q16(IDX));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!cur.y[CX_W-1]) begin
        nxt.x <= cur.x + ys;
        nxt.y <= cur.y - xs;
        nxt.z <= cur.z + step;
      end else begin
        nxt.x <= cur.x - ys;
        nxt.y <= cur.y + xs;
        nxt.z <= cur.z - step;
      end
    end
  end

endmodule

[rtl/tsa_delay.sv]
module tsa_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

[rtl/triangle_sides_and_angles_unit.sv]
// CORDIC_STAGES is capped at 24
// throughput: one triangle per cycle; the whole cell chain advances together and
// freezes only while a finished result waits on a stalled output
// reset: synchronous, clears the stage valid bits only; datapath registers are not reset
module triangle_sides_and_angles_unit import tsa_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input logic          clk,
  input logic          rst,
  tsa_item_if.sink     item,
  tsa_result_if.source result
);

  localparam int NCS = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
  localparam int LAT = 62 + NCS;

  // stage map (register sets counted from the input transfer):
  //   1 operand magnitudes, 2 squares, 3 radicand, 4..20 side square root,
  //   21 products, 22 cosine numerator/denominator, 23 magnitude and sign,
  //   24 dividend and range check, 25..41 cosine divide, 42 m*m, 43 1-m*m,
  //   44..60 sine square root, 61 cordic start, 62..61+N cordic, 62+N output

  logic           en;
  logic [LAT-1:0] vld;

  // one stall signal for the whole chain
  assign en         = !result.valid || result.ready;
  assign item.ready = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], item.valid};
    end
  end

  function automatic logic [SIDE_W-1:0] mag17(input logic signed [SIDE_W-1:0] v);
    logic signed [SIDE_W-1:0] n;
    n = -v;
    return v[SIDE_W-1] ? SIDE_W'(n) : SIDE_W'(v);
  endfunction

  // z in degrees Q16 to degrees Q8, rounded, clipped to [0, 180]
  function automatic logic [ANG_W-1:0] to_deg_q8(input logic signed [CZ_W-1:0] z);
    logic [CZ_W-1:0] r;
    r = (CZ_W'(z) + CZ_W'(128)) >> 8;
    if (z[CZ_W-1]) begin
      return '0;
    end
    if (r > CZ_W'(DEG180_Q8)) begin
      return DEG180_Q8;
    end
    return ANG_W'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // stage 1: vertex differences, or the given side with a zero partner
  // lane 0 is side a (C to B), lane 1 side b (A to C), lane 2 side c (A to B)
  // ---------------------------------------------------------------------------
  logic signed [SIDE_W-1:0] dx [3];
  logic signed [SIDE_W-1:0] dy [3];
  logic [SIDE_W-1:0]        len_in [3];
  logic [SIDE_W-1:0]        u1 [3];
  logic [SIDE_W-1:0]        v1 [3];

  assign dx[0] = SIDE_W'(item.vert_c_x) - SIDE_W'(item.vert_b_x);
  assign dy[0] = SIDE_W'(item.vert_c_y) - SIDE_W'(item.vert_b_y);
  assign dx[1] = SIDE_W'(item.vert_a_x) - SIDE_W'(item.vert_c_x);
  assign dy[1] = SIDE_W'(item.vert_a_y) - SIDE_W'(item.vert_c_y);
  assign dx[2] = SIDE_W'(item.vert_a_x) - SIDE_W'(item.vert_b_x);
  assign dy[2] = SIDE_W'(item.vert_a_y) - SIDE_W'(item.vert_b_y);
  assign len_in[0] = item.len_a_in;
  assign len_in[1] = item.len_b_in;
  assign len_in[2] = item.len_c_in;

  // a given side goes through the same root as len^2, which returns it exactly
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u1[i] <= item.op ? mag17(dx[i]) : len_in[i];
        v1[i] <= item.op ? mag17(dy[i]) : '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2..3: squared distance
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] uu2 [3];
  logic [RAD_W-1:0] vv2 [3];
  sqrt_st_t         sq  [3][SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        uu2[i] <= RAD_W'(u1[i]) * RAD_W'(u1[i]);
        vv2[i] <= RAD_W'(v1[i]) * RAD_W'(v1[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sq_start
    always_ff @(posedge clk) begin
      if (en) begin
        sq[i][0].rem  <= '0;
        sq[i][0].root <= '0;
        sq[i][0].rad  <= uu2[i] + vv2[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 4..20: one root bit per cell
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] side [3];

  for (genvar i = 0; i < 3; i++) begin : g_side_root
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
      tsa_sqrt_cell u_cell (
        .clk (clk),
        .en  (en),
        .cur (sq[i][k]),
        .nxt (sq[i][k+1])
      );
    end
    assign side[i] = sq[i][SQRT_STEPS].root;
  end

  // ---------------------------------------------------------------------------
  // stage 21: squares and pair products of the sides, zero-side check
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] ss21 [3];
  logic [RAD_W-1:0] pr21 [3];
  logic             zero21;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ss21[i] <= RAD_W'(side[i]) * RAD_W'(side[i]);
        pr21[i] <= RAD_W'(side[(i+1)%3]) * RAD_W'(side[(i+2)%3]);
      end
      zero21 <= (side[0] == '0) || (side[1] == '0) || (side[2] == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stages 22..24: law of cosines numerator, magnitude, range check, dividend
  // ---------------------------------------------------------------------------
  logic signed [NUM_W-1:0] num22 [3];
  logic [DEN_W-1:0]        den22 [3];
  logic [DEN_W-1:0]        mag23 [3];
  logic [DEN_W-1:0]        den23 [3];
  logic [2:0]              neg23;
  logic [2:0]              bad24;
  div_st_t                 dv [3][Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num22[i] <= NUM_W'(ss21[(i+1)%3]) + NUM_W'(ss21[(i+2)%3]) - NUM_W'(ss21[i]);
        den22[i] <= {pr21[i], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg23[i] <= num22[i][NUM_W-1];
        mag23[i] <= num22[i][NUM_W-1] ? DEN_W'(-num22[i]) : DEN_W'(num22[i]);
        den23[i] <= den22[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        bad24[i] <= mag23[i] > den23[i];
      end
    end
  end

  // dividend carries the half-denominator so the quotient rounds half up
  for (genvar i = 0; i < 3; i++) begin : g_dv_start
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i][0].rem <= (DIVR_W'(mag23[i]) << FRAC_W) + DIVR_W'(den23[i] >> 1);
        dv[i][0].den <= den23[i];
        dv[i][0].q   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stages 25..41: cosine magnitude m, one quotient bit per cell, msb first
  // ---------------------------------------------------------------------------
  logic [Q_W-1:0] m41 [3];

  for (genvar i = 0; i < 3; i++) begin : g_divide
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
      tsa_div_cell #(.SHIFT(Q_W - 1 - k)) u_cell (
        .clk (clk),
        .en  (en),
        .cur (dv[i][k]),
        .nxt (dv[i][k+1])
      );
    end
    assign m41[i] = dv[i][Q_W].q;
  end

  // ---------------------------------------------------------------------------
  // stages 42..60: sine = sqrt(1 - m^2)
  // ---------------------------------------------------------------------------
  logic [RAD_W-1:0] mm42 [3];
  sqrt_st_t         sn  [3][SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mm42[i] <= RAD_W'(m41[i]) * RAD_W'(m41[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_sn_start
    always_ff @(posedge clk) begin
      if (en) begin
        sn[i][0].rem  <= '0;
        sn[i][0].root <= '0;
        sn[i][0].rad  <= ONE_SQ - mm42[i];
      end
    end
  end

  logic [SIDE_W-1:0] sine [3];

  for (genvar i = 0; i < 3; i++) begin : g_sine_root
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
      tsa_sqrt_cell u_cell (
        .clk (clk),
        .en  (en),
        .cur (sn[i][k]),
        .nxt (sn[i][k+1])
      );
    end
    assign sine[i] = sn[i][SQRT_STEPS].root;
  end

  // m and the cosine sign ride alongside to the cordic start
  logic [3*Q_W-1:0] m_line_d;
  logic [3*Q_W-1:0] m_line_q;
  logic [2:0]       neg60;

  assign m_line_d = {m41[2], m41[1], m41[0]};

  tsa_delay #(.W(3*Q_W), .DEPTH(19)) u_m_dly (
    .clk (clk),
    .en  (en),
    .d   (m_line_d),
    .q   (m_line_q)
  );

  tsa_delay #(.W(3), .DEPTH(37)) u_neg_dly (
    .clk (clk),
    .en  (en),
    .d   (neg23),
    .q   (neg60)
  );

  // ---------------------------------------------------------------------------
  // stage 61: cordic start; a negative cosine starts a quarter turn ahead
  // ---------------------------------------------------------------------------
  cordic_st_t cv [3][NCS+1];

  for (genvar i = 0; i < 3; i++) begin : g_cv_start
    always_ff @(posedge clk) begin
      if (en) begin
        if (neg60[i]) begin
          cv[i][0].x <= CX_W'(sine[i]);
          cv[i][0].y <= CX_W'(m_line_q[i*Q_W +: Q_W]);
          cv[i][0].z <= DEG90_Q16;
        end else begin
          cv[i][0].x <= CX_W'(m_line_q[i*Q_W +: Q_W]);
          cv[i][0].y <= CX_W'(sine[i]);
          cv[i][0].z <= '0;
        end
      end
    end
  end

  // stages 62..61+N: vectoring cells, one rotation each
  for (genvar i = 0; i < 3; i++) begin : g_cordic
    for (genvar k = 0; k < NCS; k++) begin : g_cell
      tsa_cordic_cell #(.IDX(k)) u_cell (
        .clk (clk),
        .en  (en),
        .cur (cv[i][k]),
        .nxt (cv[i][k+1])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // side band: sides and error flags wait for the angles
  // ---------------------------------------------------------------------------
  logic [3*SIDE_W-1:0] side_line_d;
  logic [3*SIDE_W-1:0] side_out;
  logic                zero_out;
  logic [2:0]          range_out;

  assign side_line_d = {side[2], side[1], side[0]};

  tsa_delay #(.W(3*SIDE_W), .DEPTH(41 + NCS)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d   (side_line_d),
    .q   (side_out)
  );

  tsa_delay #(.W(1), .DEPTH(40 + NCS)) u_zero_dly (
    .clk (clk),
    .en  (en),
    .d   (zero21),
    .q   (zero_out)
  );

  tsa_delay #(.W(3), .DEPTH(37 + NCS)) u_range_dly (
    .clk (clk),
    .en  (en),
    .d   (bad24),
    .q   (range_out)
  );

  // ---------------------------------------------------------------------------
  // output register: a rejected triangle keeps its sides and shows zero angles
  // ---------------------------------------------------------------------------
  logic bad_any;

  assign bad_any = zero_out || (range_out != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      result.len_a_out    <= side_out[0*SIDE_W +: SIDE_W];
      result.len_b_out    <= side_out[1*SIDE_W +: SIDE_W];
      result.len_c_out    <= side_out[2*SIDE_W +: SIDE_W];
      result.angle_at_a   <= bad_any ? '0 : to_deg_q8(cv[0][NCS].z);
      result.angle_at_b   <= bad_any ? '0 : to_deg_q8(cv[1][NCS].z);
      result.angle_at_c   <= bad_any ? '0 : to_deg_q8(cv[2][NCS].z);
      result.bad_triangle <= bad_any;
    end
  end

endmodule

[rtl/tsa_check.sv]
module tsa_check import tsa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             res_valid,
  input logic             res_ready,
  input logic [ANG_W-1:0] ang_a,
  input logic [ANG_W-1:0] ang_b,
  input logic [ANG_W-1:0] ang_c,
  input logic             bad
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(ang_a) && $stable(ang_b)
      && $stable(ang_c) && $stable(bad))
    else $error("stalled result changed");

  // rejected triangle shows no angles
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad |-> ang_a == '0 && ang_b == '0 && ang_c == '0)
    else $error("angles on rejected triangle");

  // angles never pass 180 degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ang_a <= DEG180_Q8 && ang_b <= DEG180_Q8 && ang_c <= DEG180_Q8)
    else $error("angle above 180 degrees");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind triangle_sides_and_angles_unit tsa_check u_tsa_check (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .ang_a     (result.angle_at_a),
  .ang_b     (result.angle_at_b),
  .ang_c     (result.angle_at_c),
  .bad       (result.bad_triangle)
);
